FILE: rtl/mbd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the mipmap box downsampler.
package mbd_pkg;

    localparam int CHAN_W  = 8;
    localparam int NCHAN   = 4;
    localparam int SUM_W   = 9;
    localparam int LINE_W  = NCHAN * SUM_W;
    localparam int PIX_W   = NCHAN * CHAN_W;
    localparam int CFG_W   = 13;
    localparam int ROW_W   = 12;
    localparam int HEIGHT_LIMIT = 4096;

    localparam logic REG_SRC_WIDTH  = 1'b0;
    localparam logic REG_SRC_HEIGHT = 1'b1;

    typedef struct packed {
        logic [LINE_W-1:0] hsum;
        logic              hshift;
        logic              use_above;
        logic              last;
    } mbd_item_t;

endpackage

FILE: rtl/mbd_line_mem.sv
`timescale 1ns / 1ps
// Line store of horizontal pair sums with a registered read port.
module mbd_line_mem #(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          addr,
    input  logic [mbd_pkg::LINE_W-1:0] wdata,
    output logic [mbd_pkg::LINE_W-1:0] rdata
);

    logic [mbd_pkg::LINE_W-1:0] mem [0:DEPTH-1];
    logic [mbd_pkg::LINE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mbd_front.sv
`timescale 1ns / 1ps
// Configuration, raster position, pending pixel and line store access.
module mbd_front #(
    parameter int MAX_WIDTH = 4096,
    parameter int ADDR_W    = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [mbd_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        accept,
    input  logic [mbd_pkg::PIX_W-1:0]   pix,
    output logic                        mem_we,
    output logic                        mem_re,
    output logic [ADDR_W-1:0]           mem_addr,
    output logic [mbd_pkg::LINE_W-1:0]  mem_wdata,
    output logic                        item_valid,
    output mbd_pkg::mbd_item_t          item
);

    localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (WW > mbd_pkg::CFG_W) ? WW : mbd_pkg::CFG_W;
    localparam int HW    = mbd_pkg::CFG_W;
    localparam logic [CMP_W-1:0] MAX_W_V = CMP_W'(MAX_WIDTH);
    localparam logic [HW-1:0]    MAX_H_V = HW'(mbd_pkg::HEIGHT_LIMIT);

    logic                       w_one_reg, w_one_next;
    logic                       h_one_reg, h_one_next;
    logic [CW-1:0]              w_m1_reg, w_m1_next;
    logic [CW-1:0]              last_col_reg, last_col_next;
    logic [mbd_pkg::ROW_W-1:0]  h_m1_reg, h_m1_next;
    logic [mbd_pkg::ROW_W-1:0]  last_row_reg, last_row_next;
    logic [CW-1:0]              col_reg, col_next;
    logic [mbd_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [mbd_pkg::PIX_W-1:0]  pend_reg, pend_next;

    logic [CMP_W-1:0]           cfg_ext;
    logic [CMP_W-1:0]           eff_w;
    logic [HW-1:0]              eff_h;
    logic                       active;
    logic                       pair_done;
    logic [mbd_pkg::LINE_W-1:0] hsum;

    always_comb
    begin
        cfg_ext = CMP_W'(cfg_data);
        if (cfg_ext == '0)
        begin
            eff_w = CMP_W'(1);
        end
        else if (cfg_ext > MAX_W_V)
        begin
            eff_w = MAX_W_V;
        end
        else
        begin
            eff_w = cfg_ext;
        end
        if (cfg_data == '0)
        begin
            eff_h = HW'(1);
        end
        else if (cfg_data > MAX_H_V)
        begin
            eff_h = MAX_H_V;
        end
        else
        begin
            eff_h = cfg_data;
        end
    end

    always_comb
    begin
        w_one_next    = w_one_reg;
        h_one_next    = h_one_reg;
        w_m1_next     = w_m1_reg;
        last_col_next = last_col_reg;
        h_m1_next     = h_m1_reg;
        last_row_next = last_row_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                mbd_pkg::REG_SRC_WIDTH:
                begin
                    w_one_next    = (eff_w == CMP_W'(1));
                    w_m1_next     = CW'(eff_w - CMP_W'(1));
                    last_col_next = (eff_w == CMP_W'(1)) ? '0
                                  : CW'((eff_w & ~CMP_W'(1)) - CMP_W'(1));
                end
                mbd_pkg::REG_SRC_HEIGHT:
                begin
                    h_one_next    = (eff_h == HW'(1));
                    h_m1_next     = mbd_pkg::ROW_W'(eff_h - HW'(1));
                    last_row_next = (eff_h == HW'(1)) ? '0
                                  : mbd_pkg::ROW_W'((eff_h & ~HW'(1)) - HW'(1));
                end
                default:
                begin
                    w_one_next = w_one_reg;
                end
            endcase
        end
    end

    assign active    = (col_reg <= last_col_reg) && (row_reg <= last_row_reg);
    assign pair_done = active && (w_one_reg || col_reg[0]);

    always_comb
    begin
        for (int i = 0; i < mbd_pkg::NCHAN; i++)
        begin
            if (w_one_reg)
            begin
                hsum[i*mbd_pkg::SUM_W +: mbd_pkg::SUM_W] =
                    mbd_pkg::SUM_W'(pix[i*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W]);
            end
            else
            begin
                hsum[i*mbd_pkg::SUM_W +: mbd_pkg::SUM_W] =
                    mbd_pkg::SUM_W'(pend_reg[i*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W])
                  + mbd_pkg::SUM_W'(pix[i*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W]);
            end
        end
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        pend_next = pend_reg;
        if (cfg_we)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (active && !w_one_reg && !col_reg[0])
            begin
                pend_next = pix;
            end
            if (col_reg == w_m1_reg)
            begin
                col_next = '0;
                row_next = (row_reg == h_m1_reg) ? '0
                         : mbd_pkg::ROW_W'(row_reg + mbd_pkg::ROW_W'(1));
            end
            else
            begin
                col_next = CW'(col_reg + CW'(1));
            end
        end
    end

    assign mem_addr   = w_one_reg ? '0 : ADDR_W'(col_reg >> 1);
    assign mem_wdata  = hsum;
    assign mem_we     = accept && pair_done && !h_one_reg && !row_reg[0];
    assign item_valid = accept && pair_done && (h_one_reg || row_reg[0]);
    assign mem_re     = item_valid && !h_one_reg;

    assign item.hsum      = hsum;
    assign item.hshift    = !w_one_reg;
    assign item.use_above = !h_one_reg;
    assign item.last      = (col_reg == last_col_reg) && (row_reg == last_row_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_one_reg    <= 1'b1;
            h_one_reg    <= 1'b1;
            w_m1_reg     <= '0;
            last_col_reg <= '0;
            h_m1_reg     <= '0;
            last_row_reg <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            pend_reg     <= '0;
        end
        else
        begin
            w_one_reg    <= w_one_next;
            h_one_reg    <= h_one_next;
            w_m1_reg     <= w_m1_next;
            last_col_reg <= last_col_next;
            h_m1_reg     <= h_m1_next;
            last_row_reg <= last_row_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            pend_reg     <= pend_next;
        end
    end

endmodule

FILE: rtl/mbd_back.sv
`timescale 1ns / 1ps
// Vertical sum, averaging shift and output register.
module mbd_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    input  mbd_pkg::mbd_item_t          item,
    input  logic [mbd_pkg::LINE_W-1:0]  above,
    output logic                        take,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic [mbd_pkg::PIX_W-1:0]   out_avg,
    output logic                        out_last
);

    logic                        s1_valid_reg, s1_valid_next;
    mbd_pkg::mbd_item_t          s1_reg;
    logic                        o_valid_reg, o_valid_next;
    logic [mbd_pkg::PIX_W-1:0]   o_avg_reg;
    logic                        o_last_reg;
    logic                        s1_adv;
    logic [mbd_pkg::PIX_W-1:0]   res;
    logic [mbd_pkg::SUM_W:0]     vsum;

    assign s1_adv = s1_valid_reg && (!o_valid_reg || out_ready);
    assign take   = !s1_valid_reg || s1_adv;

    always_comb
    begin
        vsum = '0;
        for (int i = 0; i < mbd_pkg::NCHAN; i++)
        begin
            if (s1_reg.use_above)
            begin
                vsum = (mbd_pkg::SUM_W+1)'(above[i*mbd_pkg::SUM_W +: mbd_pkg::SUM_W])
                     + (mbd_pkg::SUM_W+1)'(s1_reg.hsum[i*mbd_pkg::SUM_W +: mbd_pkg::SUM_W]);
                vsum = vsum >> ({1'b0, s1_reg.hshift} + 2'd1);
            end
            else
            begin
                vsum = (mbd_pkg::SUM_W+1)'(s1_reg.hsum[i*mbd_pkg::SUM_W +: mbd_pkg::SUM_W]);
                vsum = vsum >> s1_reg.hshift;
            end
            res[i*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W] = vsum[mbd_pkg::CHAN_W-1:0];
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
        begin
            s1_valid_next = item_valid;
        end
        o_valid_next = o_valid_reg;
        if (s1_adv)
        begin
            o_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            o_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            o_valid_reg  <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && item_valid)
        begin
            s1_reg <= item;
        end
        if (s1_adv)
        begin
            o_avg_reg  <= res;
            o_last_reg <= s1_reg.last;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_avg   = o_avg_reg;
    assign out_last  = o_last_reg;

endmodule

FILE: rtl/mipmap_box_downsampler_top.sv
`timescale 1ns / 1ps
// Top level of the 2x2 box mipmap downsampler.
// The source word that completes a block is captured in the stage-one register, and its result
// word is registered from there in the output register.
// Throughput: one source word per cycle; a result stall holds the input once both stages are full.
// The line store has a registered read port and is not cleared at reset.
// Reset clears position, pending pixel, pipeline valids and sets both sizes to 1.
module mipmap_box_downsampler_top #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [mbd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [mbd_pkg::CHAN_W-1:0] chan0,
    input  logic [mbd_pkg::CHAN_W-1:0] chan1,
    input  logic [mbd_pkg::CHAN_W-1:0] chan2,
    input  logic [mbd_pkg::CHAN_W-1:0] chan3,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [mbd_pkg::CHAN_W-1:0] avg0,
    output logic [mbd_pkg::CHAN_W-1:0] avg1,
    output logic [mbd_pkg::CHAN_W-1:0] avg2,
    output logic [mbd_pkg::CHAN_W-1:0] avg3,
    output logic                       last_pixel
);

    localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
    localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic                       accept;
    logic                       take;
    logic                       mem_we;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_addr;
    logic [mbd_pkg::LINE_W-1:0] mem_wdata;
    logic [mbd_pkg::LINE_W-1:0] mem_rdata;
    logic                       item_valid;
    mbd_pkg::mbd_item_t         item;
    logic [mbd_pkg::PIX_W-1:0]  out_avg;

    assign in_ready = take;
    assign accept   = in_valid && take;

    mbd_front #(
        .MAX_WIDTH (MAX_WIDTH),
        .ADDR_W    (ADDR_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .pix        ({chan3, chan2, chan1, chan0}),
        .mem_we     (mem_we),
        .mem_re     (mem_re),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .item_valid (item_valid),
        .item       (item)
    );

    mbd_line_mem #(
        .DEPTH  (LINE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_line_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    mbd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .above      (mem_rdata),
        .take       (take),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_avg    (out_avg),
        .out_last   (last_pixel)
    );

    assign avg0 = out_avg[0*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];
    assign avg1 = out_avg[1*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];
    assign avg2 = out_avg[2*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];
    assign avg3 = out_avg[3*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];

endmodule

FILE: bench/mipmap_box_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the downsampled pixel stream and compares it with the block output.
module mipmap_box_checker #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [mbd_pkg::CFG_W-1:0]  cfg_data,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [mbd_pkg::CHAN_W-1:0] chan0,
    input  logic [mbd_pkg::CHAN_W-1:0] chan1,
    input  logic [mbd_pkg::CHAN_W-1:0] chan2,
    input  logic [mbd_pkg::CHAN_W-1:0] chan3,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [mbd_pkg::CHAN_W-1:0] avg0,
    input  logic [mbd_pkg::CHAN_W-1:0] avg1,
    input  logic [mbd_pkg::CHAN_W-1:0] avg2,
    input  logic [mbd_pkg::CHAN_W-1:0] avg3,
    input  logic                       last_pixel,
    output int                         errors,
    output int                         outstanding
);

    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    typedef struct packed {
        logic [mbd_pkg::NCHAN-1:0][mbd_pkg::CHAN_W-1:0] avg;
        logic                                           last;
    } mip_pixel_t;

    logic [mbd_pkg::LINE_W-1:0]                     pair_line [LINE_DEPTH];
    logic [mbd_pkg::NCHAN-1:0][mbd_pkg::CHAN_W-1:0] held_pixel;
    int unsigned                                    col_pos;
    int unsigned                                    row_pos;
    logic [mbd_pkg::CFG_W-1:0]                      width_reg;
    logic [mbd_pkg::CFG_W-1:0]                      height_reg;
    mip_pixel_t                                     expected_pixels [$];

    function automatic int unsigned clamp_size(input logic [mbd_pkg::CFG_W-1:0] v,
                                               input int unsigned hi);
        if (v == 0)
        begin
            return 1;
        end
        return (32'(v) > hi) ? hi : 32'(v);
    endfunction

    task automatic downsample_pixel(input logic [mbd_pkg::NCHAN-1:0][mbd_pkg::CHAN_W-1:0] px);
        int unsigned                w;
        int unsigned                h;
        int unsigned                c;
        int unsigned                r;
        int unsigned                ox;
        int unsigned                oy;
        int unsigned                wo;
        int unsigned                ho;
        int unsigned                shift;
        int unsigned                hsum [mbd_pkg::NCHAN];
        logic                       have_sum;
        logic                       emit;
        logic [mbd_pkg::LINE_W-1:0] line_word;
        mip_pixel_t                 word;
        w = clamp_size(width_reg, MAX_WIDTH);
        h = clamp_size(height_reg, mbd_pkg::HEIGHT_LIMIT);
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;
        shift = 0;
        have_sum = 1'b0;
        emit = 1'b0;
        word = '0;
        if ((w == 1 || c < (w & ~1)) && (h == 1 || r < (h & ~1)))
        begin
            if (w == 1)
            begin
                for (int i = 0; i < mbd_pkg::NCHAN; i++)
                begin
                    hsum[i] = 32'(px[i]);
                end
                have_sum = 1'b1;
            end
            else if (c % 2 == 0)
            begin
                held_pixel = px;
            end
            else
            begin
                for (int i = 0; i < mbd_pkg::NCHAN; i++)
                begin
                    hsum[i] = 32'(held_pixel[i]) + 32'(px[i]);
                end
                shift = 1;
                have_sum = 1'b1;
            end
            if (have_sum)
            begin
                ox = (w == 1) ? 0 : c / 2;
                oy = (h == 1) ? 0 : r / 2;
                wo = (w == 1) ? 1 : w / 2;
                ho = (h == 1) ? 1 : h / 2;
                if (h == 1)
                begin
                    for (int i = 0; i < mbd_pkg::NCHAN; i++)
                    begin
                        word.avg[i] = mbd_pkg::CHAN_W'(hsum[i] >> shift);
                    end
                    emit = 1'b1;
                end
                else if (r % 2 == 0)
                begin
                    for (int i = 0; i < mbd_pkg::NCHAN; i++)
                    begin
                        line_word[i*mbd_pkg::SUM_W +: mbd_pkg::SUM_W] = mbd_pkg::SUM_W'(hsum[i]);
                    end
                    pair_line[ox] = line_word;
                end
                else
                begin
                    line_word = pair_line[ox];
                    for (int i = 0; i < mbd_pkg::NCHAN; i++)
                    begin
                        word.avg[i] = mbd_pkg::CHAN_W'(
                            (32'(line_word[i*mbd_pkg::SUM_W +: mbd_pkg::SUM_W]) + hsum[i])
                            >> (shift + 1));
                    end
                    emit = 1'b1;
                end
                if (emit)
                begin
                    word.last = (ox == wo - 1) && (oy == ho - 1);
                    expected_pixels.push_back(word);
                end
            end
        end
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
            begin
                r = 0;
            end
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    task automatic compare_pixel();
        mip_pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            $display("%0t: unexpected word, expected none, actual avg=%02h %02h %02h %02h last=%0b",
                     $time, avg0, avg1, avg2, avg3, last_pixel);
            errors++;
        end
        else
        begin
            want = expected_pixels.pop_front();
            check_field("avg0", int'(want.avg[0]), int'(avg0));
            check_field("avg1", int'(want.avg[1]), int'(avg1));
            check_field("avg2", int'(want.avg[2]), int'(avg2));
            check_field("avg3", int'(want.avg[3]), int'(avg3));
            check_field("last_pixel", int'(want.last), int'(last_pixel));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_pixel = '0;
            col_pos = 0;
            row_pos = 0;
            width_reg = mbd_pkg::CFG_W'(1);
            height_reg = mbd_pkg::CFG_W'(1);
            errors = 0;
            expected_pixels.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                compare_pixel();
            end
            if (cfg_we)
            begin
                if (cfg_index == mbd_pkg::REG_SRC_WIDTH)
                begin
                    width_reg = cfg_data;
                end
                else
                begin
                    height_reg = cfg_data;
                end
                col_pos = 0;
                row_pos = 0;
            end
            if (in_valid && in_ready)
            begin
                downsample_pixel({chan3, chan2, chan1, chan0});
            end
        end
        outstanding = expected_pixels.size();
    end

endmodule

FILE: bench/tb_mipmap_box_downsampler_top.sv
`timescale 1ns / 1ps
// Testbench top that drives images through the mipmap downsampler and reports the verdict.
module tb_mipmap_box_downsampler_top;

    localparam int MAX_WIDTH     = 4096;
    localparam int PIXEL_TARGET  = 950;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int IMAGE_CAP     = 240;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic                       cfg_index;
    logic [mbd_pkg::CFG_W-1:0]  cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic [mbd_pkg::CHAN_W-1:0] chan0;
    logic [mbd_pkg::CHAN_W-1:0] chan1;
    logic [mbd_pkg::CHAN_W-1:0] chan2;
    logic [mbd_pkg::CHAN_W-1:0] chan3;
    logic                       out_valid;
    logic                       out_ready;
    logic [mbd_pkg::CHAN_W-1:0] avg0;
    logic [mbd_pkg::CHAN_W-1:0] avg1;
    logic [mbd_pkg::CHAN_W-1:0] avg2;
    logic [mbd_pkg::CHAN_W-1:0] avg3;
    logic                       last_pixel;
    int                         errors;
    int                         outstanding;
    int                         sent_count = 0;
    int                         burst_left = 0;
    int                         cycle_count = 0;
    logic                       steady = 1'b0;

    mipmap_box_downsampler_top #(.MAX_WIDTH(MAX_WIDTH)) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .chan0      (chan0),
        .chan1      (chan1),
        .chan2      (chan2),
        .chan3      (chan3),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .avg0       (avg0),
        .avg1       (avg1),
        .avg2       (avg2),
        .avg3       (avg3),
        .last_pixel (last_pixel)
    );

    mipmap_box_checker #(.MAX_WIDTH(MAX_WIDTH)) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .chan0       (chan0),
        .chan1       (chan1),
        .chan2       (chan2),
        .chan3       (chan3),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .avg0        (avg0),
        .avg1        (avg1),
        .avg2        (avg2),
        .avg3        (avg3),
        .last_pixel  (last_pixel),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic logic [mbd_pkg::PIX_W-1:0] rand_pixel();
        logic [mbd_pkg::PIX_W-1:0] px;
        for (int i = 0; i < mbd_pkg::NCHAN; i++)
        begin
            case ($urandom_range(0, 7))
                0:       px[i*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W] = '0;
                1:       px[i*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W] = '1;
                default: px[i*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W] =
                             mbd_pkg::CHAN_W'($urandom_range(0, 255));
            endcase
        end
        return px;
    endfunction

    function automatic int pick_size(input int span);
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return $urandom_range(0, 1) ? mbd_pkg::HEIGHT_LIMIT : 8191;
            2:       return 1;
            3:       return 2;
            4, 5:    return $urandom_range(13, span);
            default: return $urandom_range(3, 12);
        endcase
    endfunction

    function automatic int eff_size(input int v);
        if (v == 0)
        begin
            return 1;
        end
        return (v > MAX_WIDTH) ? MAX_WIDTH : v;
    endfunction

    task automatic send_pixel(input logic [mbd_pkg::PIX_W-1:0] px);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        chan0 <= px[0*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];
        chan1 <= px[1*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];
        chan2 <= px[2*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];
        chan3 <= px[3*mbd_pkg::CHAN_W +: mbd_pkg::CHAN_W];
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    task automatic drain_block();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (8) @(negedge clk);
    endtask

    task automatic set_size(input int w, input int h);
        drain_block();
        cfg_we <= 1'b1;
        cfg_index <= mbd_pkg::REG_SRC_WIDTH;
        cfg_data <= w[mbd_pkg::CFG_W-1:0];
        @(negedge clk);
        cfg_index <= mbd_pkg::REG_SRC_HEIGHT;
        cfg_data <= h[mbd_pkg::CFG_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int hold_left;
        int holds_done;
        int mode;
        int mode_left;
        int phase;
        logic take;
        hold_left = 0;
        holds_done = 0;
        mode = 0;
        mode_left = 0;
        phase = 0;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && holds_done < 2 && sent_count >= 300 + 400 * holds_done)
            begin
                hold_left = 250;
                holds_done++;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            phase++;
            case (mode)
                0:       take = 1'b1;
                1:       take = 1'($urandom_range(0, 1));
                2:       take = ($urandom_range(0, 3) != 0);
                default: take = (phase % 4 != 0);
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            out_ready <= take;
        end
    end

    initial
    begin
        int w;
        int h;
        int count;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mbd_pkg::REG_SRC_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        chan0 = '0;
        chan1 = '0;
        chan2 = '0;
        chan3 = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset size is 1x1, so every word passes straight through.
        send_pixel('0);
        send_pixel('1);
        send_pixel(32'h55AA_55AA);
        set_size(2, 2);
        repeat (4) send_pixel('1);
        set_size(3, 3);
        repeat (9) send_pixel(rand_pixel());
        set_size(0, 0);
        send_pixel(rand_pixel());
        set_size(8191, 1);
        repeat (4) send_pixel(rand_pixel());
        set_size(1, 8191);
        repeat (4) send_pixel(rand_pixel());

        while (sent_count < PIXEL_TARGET)
        begin
            w = pick_size(40);
            h = pick_size(24);
            set_size(w, h);
            steady = ($urandom_range(0, 4) == 0);
            count = eff_size(w) * eff_size(h);
            if ($urandom_range(0, 5) == 0)
            begin
                count = $urandom_range(1, count);
            end
            else
            begin
                count = count * $urandom_range(1, 2);
            end
            if (count > IMAGE_CAP)
            begin
                count = IMAGE_CAP;
            end
            if (count > PIXEL_TARGET - sent_count)
            begin
                count = PIXEL_TARGET - sent_count;
            end
            repeat (count) send_pixel(rand_pixel());
        end

        drain_block();
        repeat (12) @(negedge clk);
        if (errors == 0 && outstanding == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
